// File: src/lpcd_pkg.sv
// ----------------------------------------------------------------------------
// lpcd_pkg
// Shared types and constants for the longest-path block.
// ----------------------------------------------------------------------------
package lpcd_pkg;

    localparam int MaxNodesDef = 256;
    localparam int MaxEdgesDef = 1024;

    localparam int DistW = 48;
    localparam int NodeW = 9;
    localparam int WgtW  = 32;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    // Configuration register byte addresses
    localparam logic [1:0] REG_NODE_COUNT = 2'd0;

    localparam logic signed [DistW-1:0] DistHi = {1'b0, {(DistW-1){1'b1}}};
    localparam logic signed [DistW-1:0] DistLo = {1'b1, {(DistW-1){1'b0}}};

    // Controller to datapath commands
    typedef struct packed {
        logic clr_nodes;   // sweep node stores, step clear address
        logic seed;        // seed node 1 as reached
        logic rd_edge;     // read the edge at the scan address
        logic relax;       // relax the edge held in the edge read register
        logic scan_rst;    // restart the edge scan
        logic late;        // current pass is n or later
        logic rd_target;   // read distance and flags of node n
        logic rd_nodes;    // read node stores at both edge endpoints
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic scan_last;   // scan address points at the final edge
        logic no_edges;
    } t_stat;

endpackage

// File: src/lpcd_datapath.sv
// ----------------------------------------------------------------------------
// lpcd_datapath
// Edge memory, node stores and the relaxation unit.
// ----------------------------------------------------------------------------
module lpcd_datapath
    import lpcd_pkg::*;
#(
    parameter int MAX_NODES = MaxNodesDef,
    parameter int MAX_EDGES = MaxEdgesDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_add,
    input  logic                    i_clear_edges,
    input  logic [NodeW-1:0]        i_src,
    input  logic [NodeW-1:0]        i_dst,
    input  logic signed [WgtW-1:0]  i_wgt,
    input  logic [NodeW-1:0]        i_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic [NodeW-1:0]        o_edge_src,
    output logic signed [DistW-1:0] o_dist,
    output logic                    o_inf,
    output logic                    o_reached
);
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int NA = $clog2(MAX_NODES);
    localparam int EW = 2*NodeW + WgtW;

    // Edges stay in insertion order; a pass sweeps source s = 1..n and scans
    // every edge for each s, so edges are relaxed by ascending source.
    logic [EW-1:0] r_edges [MAX_EDGES];
    logic [EW-1:0] r_edge_q;
    logic [CW-1:0] r_total;
    logic [EA-1:0] r_scan;

    logic signed [DistW-1:0] r_dist [MAX_NODES];
    logic [1:0]              r_flags [MAX_NODES];
    logic [NA-1:0]           r_clr;

    // Registered node store reads
    logic signed [DistW-1:0] r_ds, r_dt;
    logic [1:0]              r_fs, r_ft;

    logic [NodeW-1:0]        e_s, e_t;
    logic signed [WgtW-1:0]  e_w;
    logic                    e_ok;
    logic [NA-1:0]           s_a, t_a, n_a, rd_a;
    logic signed [DistW+1:0] cand;
    logic signed [DistW-1:0] sat;

    // Edge store and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_clear_edges) begin
            r_total <= '0;
        end else if (i_add && r_total < CW'(MAX_EDGES)) begin
            r_total <= r_total + 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_add && r_total < CW'(MAX_EDGES))
            r_edges[r_total[EA-1:0]] <= {i_wgt, i_dst, i_src};
        if (i_cmd.rd_edge)
            r_edge_q <= r_edges[r_scan];
    end

    // Advance the edge scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_rst) r_scan <= '0;
        else if (i_cmd.rd_edge)        r_scan <= r_scan + 1'b1;
    end
    assign o_stat.scan_last = (CW'(r_scan) + 1'b1 >= r_total);
    assign o_stat.no_edges  = (r_total == '0);

    // Decode the read edge
    assign e_s  = r_edge_q[NodeW-1:0];
    assign e_t  = r_edge_q[2*NodeW-1:NodeW];
    assign e_w  = r_edge_q[EW-1:2*NodeW];
    assign e_ok = e_s != '0 && e_s <= i_n && e_t != '0 && e_t <= i_n;
    assign o_edge_src = e_s;

    assign s_a  = NA'(e_s - 1'b1);
    assign t_a  = NA'(e_t - 1'b1);
    assign n_a  = NA'(i_n - 1'b1);
    assign rd_a = i_cmd.rd_target ? n_a : s_a;

    // Read source (or target node n) and edge target from the node stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_nodes || i_cmd.rd_target) begin
            r_ds <= r_dist[rd_a];
            r_fs <= r_flags[rd_a];
        end
        if (i_cmd.rd_nodes) begin
            r_dt <= r_dist[t_a];
            r_ft <= r_flags[t_a];
        end
    end

    assign cand = (DistW+2)'(r_ds) + (DistW+2)'(e_w);

    always_comb begin
        if (cand > (DistW+2)'(DistHi))      sat = DistHi;
        else if (cand < (DistW+2)'(DistLo)) sat = DistLo;
        else                                sat = cand[DistW-1:0];
    end

    // Relax one edge: flags bit0 reached, bit1 infinite
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_nodes) begin
            r_flags[r_clr] <= 2'b00;
            r_dist[r_clr]  <= '0;
        end else if (i_cmd.seed) begin
            r_flags[0] <= 2'b01;
        end else if (i_cmd.relax && e_ok && r_fs[0]) begin
            if (r_fs[1]) begin
                if (!r_ft[1]) r_flags[t_a] <= 2'b11;
            end else if (!r_ft[1] && (!r_ft[0] || cand > (DistW+2)'(r_dt))) begin
                if (i_cmd.late) r_flags[t_a] <= 2'b11;
                else begin
                    r_flags[t_a] <= 2'b01;
                    r_dist[t_a]  <= sat;
                end
            end
        end
    end

    // Step the clear address, wrap after the last node
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr_nodes) r_clr <= o_stat.clr_done ? '0 : r_clr + 1'b1;
    end
    assign o_stat.clr_done = (r_clr == NA'(MAX_NODES - 1));

    assign o_dist    = r_ds;
    assign o_inf     = r_fs[1];
    assign o_reached = r_fs[0];
endmodule

// File: src/lpcd_ctrl.sv
// ----------------------------------------------------------------------------
// lpcd_ctrl
// Sequencer for node clear, relaxation passes and result delivery.
// ----------------------------------------------------------------------------
module lpcd_ctrl
    import lpcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NodeW-1:0] i_n,
    input  t_stat            i_stat,
    output t_cmd             o_cmd,
    output logic [NodeW-1:0] o_src,
    output logic             o_busy,
    output logic             o_done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_SEED = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_NRD  = 3'd4;
    localparam logic [2:0] S_REL  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [NodeW:0]   r_pass, n_pass;
    logic [NodeW-1:0] r_src, n_src;
    logic             r_last, n_last;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_src   = r_src;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.late = (r_pass >= {1'b0, i_n});
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_CLR;
            S_CLR: begin
                o_cmd.clr_nodes = 1'b1;
                if (i_stat.clr_done) n_state = S_SEED;
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                o_cmd.scan_rst = 1'b1;
                n_pass = (NodeW+1)'(1);
                n_src  = NodeW'(1);
                n_state = i_stat.no_edges ? S_FIN : S_RD;
            end
            S_RD: begin
                o_cmd.rd_edge = 1'b1;
                n_last  = i_stat.scan_last;
                n_state = S_NRD;
            end
            S_NRD: begin
                o_cmd.rd_nodes = 1'b1;
                n_state = S_REL;
            end
            S_REL: begin
                // only edges of the current source are relaxed this sweep
                o_cmd.relax = 1'b1;
                n_state = S_RD;
                if (r_last) begin
                    o_cmd.scan_rst = 1'b1;
                    if (r_src >= i_n) begin
                        n_src = NodeW'(1);
                        if (r_pass >= {i_n, 1'b0}) n_state = S_FIN;
                        else n_pass = r_pass + 1'b1;
                    end else n_src = r_src + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.rd_target = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
    assign o_busy = (r_state != S_IDLE);
    assign o_src  = r_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= '0;
            r_src   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_src   <= n_src;
            r_last  <= n_last;
        end
    end
endmodule

// File: src/lpcd_srcgate.sv
// ----------------------------------------------------------------------------
// lpcd_srcgate
// Current-source filter: passes relax only for edges of the swept source.
// ----------------------------------------------------------------------------
module lpcd_srcgate
    import lpcd_pkg::*;
(
    input  t_cmd             i_cmd,
    input  logic [NodeW-1:0] i_cur_src,
    input  logic [NodeW-1:0] i_edge_src,
    output t_cmd             o_cmd
);
    // Drop relax for edges whose source is not the one being swept
    always_comb begin
        o_cmd = i_cmd;
        o_cmd.relax = i_cmd.relax && (i_edge_src == i_cur_src);
    end
endmodule

// File: src/longest_path_with_cycle_detect.sv
// ----------------------------------------------------------------------------
// longest_path_with_cycle_detect
// Bellman-Ford longest path from node 1 to node n with positive-cycle flag.
// ----------------------------------------------------------------------------
// Clear (cmd 0) and add-edge (cmd 1) requests may follow back to back. A
// run request (cmd 2) first sweeps the node stores, seeds node 1, then, if
// any edges are stored, makes 2*n passes; each pass visits source nodes 1..n
// in turn and scans all stored edges for each, one edge at a time (edge
// read, node read, relax). Node n is then read and the result loaded. The
// single edge memory read port and the registered node store reads set this
// per-edge sequence. No request is accepted while a run is busy or its
// result waits to be taken.
module longest_path_with_cycle_detect
    import lpcd_pkg::*;
#(
    parameter int MAX_NODES = MaxNodesDef,
    parameter int MAX_EDGES = MaxEdgesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd, [10:2] edge_source, [19:11] edge_target, [51:20] edge_weight
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [47:0] best_distance, [48] is_infinite, [49] is_unreachable
    output logic [55:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [NodeW-1:0] r_ncfg;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ncfg <= NodeW'(1);
        else if (psel && penable && pwrite && paddr == REG_NODE_COUNT)
            r_ncfg <= pwdata[NodeW-1:0];
    end
    assign prdata = (paddr == REG_NODE_COUNT) ? {{(32-NodeW){1'b0}}, r_ncfg} : 32'd0;

    // Clamp node count into 1..MAX_NODES
    logic [NodeW-1:0] eff_n;
    always_comb begin
        if (r_ncfg == '0) eff_n = NodeW'(1);
        else if (32'(r_ncfg) > MAX_NODES) eff_n = NodeW'(MAX_NODES);
        else eff_n = r_ncfg;
    end

    logic r_out_v;
    logic busy, done, acc;
    t_cmd cmd_c, cmd_g;
    t_stat stat;
    logic signed [DistW-1:0] tgt_dist;
    logic inf, reached;
    logic [NodeW-1:0] cur_src, edge_src;

    assign s_axis_tready = !busy && !r_out_v;
    assign acc = s_axis_tvalid && s_axis_tready;

    lpcd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(acc && s_axis_tdata[1:0] == CMD_RUN),
        .i_n(eff_n), .i_stat(stat), .o_cmd(cmd_c), .o_src(cur_src),
        .o_busy(busy), .o_done(done)
    );

    lpcd_srcgate u_gate (
        .i_cmd(cmd_c), .i_cur_src(cur_src), .i_edge_src(edge_src), .o_cmd(cmd_g)
    );

    lpcd_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_add(acc && s_axis_tdata[1:0] == CMD_ADD),
        .i_clear_edges(acc && s_axis_tdata[1:0] == CMD_CLEAR),
        .i_src(s_axis_tdata[10:2]), .i_dst(s_axis_tdata[19:11]),
        .i_wgt(s_axis_tdata[51:20]), .i_n(eff_n), .i_cmd(cmd_g), .o_stat(stat),
        .o_edge_src(edge_src),
        .o_dist(tgt_dist), .o_inf(inf), .o_reached(reached)
    );

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (done) r_out_v <= 1'b1;
        else if (m_axis_tready) r_out_v <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (done)
            m_axis_tdata <= {6'd0, !inf && !reached, inf,
                             (inf || !reached) ? {DistW{1'b0}} : tgt_dist};
    end
    assign m_axis_tvalid = r_out_v;
endmodule
